[rtl/core/slpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpt_pkg
// Shared widths, constants and the job record for the level/period tracker.
// ----------------------------------------------------------------------------
package slpt_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIME_BITS   = 32;
  localparam int COUNT_BITS  = 20;
  localparam int SUM_BITS    = 32;

  // Divider step counter: one quotient bit per cycle
  localparam int STEP_BITS   = $clog2(SUM_BITS);

  // Job queue between front and back
  localparam int QDEPTH      = 2;
  localparam int QPTR_BITS   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

  localparam logic [SAMPLE_BITS-1:0] LEVEL_TOP = {SAMPLE_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Statistics snapshot handed from front to back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] min_level;
    logic [SAMPLE_BITS-1:0] max_level;
    logic [TIME_BITS-1:0]   period_ms;
    logic                   crossed;
    logic [SUM_BITS-1:0]    sum;
    logic [COUNT_BITS-1:0]  count;
  } job_t;

endpackage

[rtl/core/slpt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpt_front
// Takes requests, updates running statistics and crossing state, emits jobs.
// ----------------------------------------------------------------------------
module slpt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic                           req_type,
  input  logic [slpt_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic [slpt_pkg::TIME_BITS-1:0]   time_ms,
  output logic                           job_push,
  output slpt_pkg::job_t                 job,
  input  logic                           job_full
);
  import slpt_pkg::*;

  logic [SAMPLE_BITS-1:0] low_r, low_nxt;
  logic [SAMPLE_BITS-1:0] high_r, high_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic [TIME_BITS-1:0]   xtime_r, xtime_nxt;
  logic                   xseen_r, xseen_nxt;
  logic [TIME_BITS-1:0]   period_r, period_nxt;

  logic                   accept;
  logic [SAMPLE_BITS:0]   mid_sum;
  logic [SAMPLE_BITS-1:0] mid;
  logic                   hit;
  logic [SUM_BITS:0]      sum_add;
  logic                   can_add;

  assign full     = job_full;
  assign accept   = push && !job_full;
  assign job_push = accept;

  assign mid_sum = {1'b0, low_r} + {1'b0, high_r};
  assign mid     = mid_sum[SAMPLE_BITS:1];
  assign hit     = (count_r != '0) && (prev_r < mid) && (sample_value >= mid);
  assign sum_add = {1'b0, sum_r} + {{(SUM_BITS + 1 - SAMPLE_BITS){1'b0}}, sample_value};
  assign can_add = (count_r != COUNT_MAX) && !sum_add[SUM_BITS];

  always_comb begin
    low_nxt    = low_r;
    high_nxt   = high_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    prev_nxt   = prev_r;
    xtime_nxt  = xtime_r;
    xseen_nxt  = xseen_r;
    period_nxt = period_r;
    if (accept) begin
      if (req_type == REQ_CLEAR) begin
        low_nxt    = LEVEL_TOP;
        high_nxt   = '0;
        sum_nxt    = '0;
        count_nxt  = '0;
        xtime_nxt  = '0;
        xseen_nxt  = 1'b0;
        period_nxt = '0;
      end else begin
        if (hit) begin
          if (xseen_r) begin
            period_nxt = time_ms - xtime_r;
          end
          xtime_nxt = time_ms;
          xseen_nxt = 1'b1;
        end
        prev_nxt = sample_value;
        if (sample_value < low_r) begin
          low_nxt = sample_value;
        end
        if (sample_value > high_r) begin
          high_nxt = sample_value;
        end
        if (can_add) begin
          sum_nxt   = sum_add[SUM_BITS-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    job.min_level = low_nxt;
    job.max_level = high_nxt;
    job.period_ms = period_nxt;
    job.crossed   = (req_type == REQ_SAMPLE) && hit;
    job.sum       = sum_nxt;
    job.count     = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= LEVEL_TOP;
      high_r   <= '0;
      sum_r    <= '0;
      count_r  <= '0;
      prev_r   <= '0;
      xtime_r  <= '0;
      xseen_r  <= 1'b0;
      period_r <= '0;
    end else begin
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      prev_r   <= prev_nxt;
      xtime_r  <= xtime_nxt;
      xseen_r  <= xseen_nxt;
      period_r <= period_nxt;
    end
  end

endmodule

[rtl/core/slpt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpt_queue
// Short job queue decoupling the front from the divider back end.
// ----------------------------------------------------------------------------
module slpt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slpt_pkg::job_t wr_data,
  output logic           full,
  input  logic           pop,
  output slpt_pkg::job_t rd_data,
  output logic           empty
);
  import slpt_pkg::*;

  job_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == QCNT_BITS'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/core/slpt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpt_back
// Serial restoring divider for the mean, plus the result register.
// ----------------------------------------------------------------------------
module slpt_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  slpt_pkg::job_t                   q_data,
  output logic                             q_pop,
  output logic                             empty,
  input  logic                             pop,
  output logic [slpt_pkg::SAMPLE_BITS-1:0] min_level,
  output logic [slpt_pkg::SAMPLE_BITS-1:0] max_level,
  output logic [slpt_pkg::SAMPLE_BITS-1:0] mean_level,
  output logic [slpt_pkg::TIME_BITS-1:0]   period_ms,
  output logic                             crossed
);
  import slpt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  job_t                  job_r, job_nxt;
  logic [SUM_BITS-1:0]   quo_r, quo_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] min_r, max_r, mean_r;
  logic [TIME_BITS-1:0]  period_r;
  logic                  crossed_r;

  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;
  logic                  out_free;
  logic                  load_out;

  assign shifted  = {rem_r, quo_r[SUM_BITS-1]};
  assign diff     = shifted - {1'b0, job_r.count};
  assign ge       = (shifted >= {1'b0, job_r.count});
  assign out_free = !out_valid_r || pop;
  assign load_out = (state_r == ST_DONE) && out_free;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          job_nxt  = q_data;
          rem_nxt  = '0;
          step_nxt = '0;
          if (q_data.count == '0) begin
            quo_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            quo_nxt   = q_data.sum;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        quo_nxt = {quo_r[SUM_BITS-2:0], ge};
        rem_nxt = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
        if (step_r == STEP_BITS'(SUM_BITS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (load_out) begin
      min_r     <= job_r.min_level;
      max_r     <= job_r.max_level;
      mean_r    <= quo_r[SAMPLE_BITS-1:0];
      period_r  <= job_r.period_ms;
      crossed_r <= job_r.crossed;
    end
  end

  assign empty      = !out_valid_r;
  assign min_level  = min_r;
  assign max_level  = max_r;
  assign mean_level = mean_r;
  assign period_ms  = period_r;
  assign crossed    = crossed_r;

endmodule

[rtl/core/signal_level_period_tracker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_level_period_tracker_top
// Running min/max/mean of ADC samples with rising midpoint crossing period.
// ----------------------------------------------------------------------------
//
//  channel  | handshake       | payload
//  ---------+-----------------+----------------------------------------------
//  in_      | in_push/in_full | req_type, sample_value[11:0], time_ms[31:0]
//  out_     | out_pop/out_empty | min/max/mean_level[11:0], period_ms, crossed
//
//  A request is taken by the front, which updates min, max, sum, count
//  and crossing state at once and queues a snapshot job.
//  The back runs a one-bit-per-cycle divider for the mean: a sample request
//  passes load, 32 divider steps and write-back, while a clear or an empty
//  set skips the divider steps. The serial divider sets the sustained rate.
//  Reset (rst_n low, synchronous) clears statistics, queue and result.
//  in_full rises when the two-entry job queue is full; a stalled out_pop
//  holds the result register and, behind it, the divider and the queue.
//
module signal_level_period_tracker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic                             in_req_type,
  input  logic [slpt_pkg::SAMPLE_BITS-1:0] in_sample_value,
  input  logic [slpt_pkg::TIME_BITS-1:0]   in_time_ms,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [slpt_pkg::SAMPLE_BITS-1:0] out_min_level,
  output logic [slpt_pkg::SAMPLE_BITS-1:0] out_max_level,
  output logic [slpt_pkg::SAMPLE_BITS-1:0] out_mean_level,
  output logic [slpt_pkg::TIME_BITS-1:0]   out_period_ms,
  output logic                             out_crossed
);
  import slpt_pkg::*;

  // front -> queue
  logic job_push;
  job_t job_wr;
  logic q_full;

  // queue -> back
  logic q_pop;
  job_t job_rd;
  logic q_empty;

  slpt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .full         (in_full),
    .req_type     (in_req_type),
    .sample_value (in_sample_value),
    .time_ms      (in_time_ms),
    .job_push     (job_push),
    .job          (job_wr),
    .job_full     (q_full)
  );

  slpt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (job_rd),
    .empty   (q_empty)
  );

  slpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (job_rd),
    .q_pop      (q_pop),
    .empty      (out_empty),
    .pop        (out_pop),
    .min_level  (out_min_level),
    .max_level  (out_max_level),
    .mean_level (out_mean_level),
    .period_ms  (out_period_ms),
    .crossed    (out_crossed)
  );

  // A crossing needs at least one earlier sample, so the marks are ordered
  a_cross_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_crossed) |-> (out_min_level <= out_max_level))
    else $error("crossing reported with unordered min/max");

  // With any sample held, the mean lies between min and max
  a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_min_level <= out_max_level)) |->
      ((out_mean_level >= out_min_level) && (out_mean_level <= out_max_level)))
    else $error("mean outside min/max");

  // Queue cannot be both full and empty
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("job queue flags inconsistent");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

endmodule
